// ===== hdl/owpw_pkg.sv =====
// Shared types and constants for the OLED window pixel writer.
package owpw_pkg;

  // Panel geometry
  localparam int unsigned DisplayWidth  = 128;
  localparam int unsigned DisplayHeight = 128;

  // Field widths
  localparam int unsigned CoordW = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ColorW = 16;

  // APB register map
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [1:0] {
    RegSetColumn = 2'd0,
    RegSetRow    = 2'd1,
    RegWriteRam  = 2'd2
  } reg_idx_e;

  // Reset values of the command codes
  localparam logic [ByteW-1:0] SetColumnReset = 8'd21;
  localparam logic [ByteW-1:0] SetRowReset    = 8'd117;
  localparam logic [ByteW-1:0] WriteRamReset  = 8'd92;

  // RGB565 channel masks
  localparam logic [ColorW-1:0] RedMask   = 16'hF800;
  localparam logic [ColorW-1:0] GreenMask = 16'h07E0;
  localparam logic [ColorW-1:0] BlueMask  = 16'h001F;

  // Command codes as programmed over APB
  typedef struct packed {
    logic [ByteW-1:0] set_column;
    logic [ByteW-1:0] set_row;
    logic [ByteW-1:0] write_ram;
  } cmd_codes_t;

  // One emitted pixel
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
  } pixel_t;

endpackage

// ===== hdl/owpw_if.sv =====
// Stream interfaces: incoming bus bytes and outgoing pixels.
interface owpw_byte_if;
  import owpw_pkg::*;
  logic             valid;
  logic             ready;
  logic             is_command;
  logic [ByteW-1:0] bus_byte;

  modport source (output valid, output is_command, output bus_byte, input ready);
  modport sink   (input valid, input is_command, input bus_byte, output ready);
endinterface

interface owpw_pixel_if;
  import owpw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic [ColorW-1:0] pixel_color;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  output ready);
endinterface

// ===== hdl/owpw_cfg_regs.sv =====
// APB register block holding the three command codes.
module owpw_cfg_regs import owpw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cmd_codes_t          codes_o
);

  cmd_codes_t codes_q, codes_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Write decode; addresses past the map are dropped
  always_comb begin
    codes_d = codes_q;
    if (wr_en) begin
      unique case (idx)
        RegSetColumn: codes_d.set_column = pwdata[ByteW-1:0];
        RegSetRow:    codes_d.set_row    = pwdata[ByteW-1:0];
        RegWriteRam:  codes_d.write_ram  = pwdata[ByteW-1:0];
        default:      ;
      endcase
    end
  end

  // Read decode
  always_comb begin
    prdata = '0;
    unique case (idx)
      RegSetColumn: prdata[ByteW-1:0] = codes_q.set_column;
      RegSetRow:    prdata[ByteW-1:0] = codes_q.set_row;
      RegWriteRam:  prdata[ByteW-1:0] = codes_q.write_ram;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.set_column <= SetColumnReset;
      codes_q.set_row    <= SetRowReset;
      codes_q.write_ram  <= WriteRamReset;
    end else begin
      codes_q <= codes_d;
    end
  end

  assign codes_o = codes_q;

endmodule

// ===== hdl/owpw_window_ctrl.sv =====
// Command decode, address window registers and cursor update.
module owpw_window_ctrl import owpw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             is_command_i,
  input  logic [ByteW-1:0] bus_byte_i,
  input  cmd_codes_t       codes_i,
  output logic             pix_valid_o,
  output pixel_t           pix_o
);

  localparam logic [CoordW-1:0] ColMax = CoordW'(DisplayWidth - 1);
  localparam logic [CoordW-1:0] RowMax = CoordW'(DisplayHeight - 1);

  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic              phase_q, phase_d;
  logic [CoordW-1:0] col_start_q, col_start_d, col_end_q, col_end_d;
  logic [CoordW-1:0] row_start_q, row_start_d, row_end_q, row_end_d;
  logic [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [ByteW-1:0]  high_q, high_d;

  logic              is_col, is_row, is_ram;
  logic [CoordW-1:0] col_val, row_val;
  logic [CoordW:0]   x_inc, y_inc;
  logic [ColorW-1:0] color;

  // Command match, set-column first
  assign is_col = (cmd_q == codes_i.set_column);
  assign is_row = !is_col && (cmd_q == codes_i.set_row);
  assign is_ram = !is_col && !is_row && (cmd_q == codes_i.write_ram);

  // Saturate coordinates to the panel size
  assign col_val = ({1'b0, bus_byte_i} >= 9'(DisplayWidth))  ? ColMax
                                                             : bus_byte_i[CoordW-1:0];
  assign row_val = ({1'b0, bus_byte_i} >= 9'(DisplayHeight)) ? RowMax
                                                             : bus_byte_i[CoordW-1:0];

  assign x_inc = {1'b0, cur_x_q} + 1'b1;
  assign y_inc = {1'b0, cur_y_q} + 1'b1;

  assign color = (({high_q, bus_byte_i} & RedMask) |
                  ({high_q, bus_byte_i} & GreenMask) |
                  ({high_q, bus_byte_i} & BlueMask));

  // Next-state logic for one byte
  always_comb begin
    cmd_d       = cmd_q;
    phase_d     = phase_q;
    col_start_d = col_start_q;
    col_end_d   = col_end_q;
    row_start_d = row_start_q;
    row_end_d   = row_end_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    high_d      = high_q;
    pix_valid_o = 1'b0;
    pix_o.x     = cur_x_q;
    pix_o.y     = cur_y_q;
    pix_o.color = color;

    if (take_i) begin
      if (is_command_i) begin
        cmd_d   = bus_byte_i;
        phase_d = 1'b0;
      end else if (is_col) begin
        if (!phase_q) begin
          col_start_d = col_val;
          cur_x_d     = col_val;
          phase_d     = 1'b1;
        end else begin
          col_end_d = col_val;
        end
      end else if (is_row) begin
        if (!phase_q) begin
          row_start_d = row_val;
          cur_y_d     = row_val;
          phase_d     = 1'b1;
        end else begin
          row_end_d = row_val;
        end
      end else if (is_ram) begin
        if (!phase_q) begin
          high_d  = bus_byte_i;
          phase_d = 1'b1;
        end else begin
          phase_d     = 1'b0;
          pix_valid_o = 1'b1;
          // Advance and wrap inside the window
          if (x_inc > {1'b0, col_end_q}) begin
            cur_x_d = col_start_q;
            if (y_inc > {1'b0, row_end_q}) begin
              cur_y_d = row_start_q;
            end else begin
              cur_y_d = y_inc[CoordW-1:0];
            end
          end else begin
            cur_x_d = x_inc[CoordW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      phase_q     <= 1'b0;
      col_start_q <= '0;
      col_end_q   <= '0;
      row_start_q <= '0;
      row_end_q   <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      high_q      <= '0;
    end else begin
      cmd_q       <= cmd_d;
      phase_q     <= phase_d;
      col_start_q <= col_start_d;
      col_end_q   <= col_end_d;
      row_start_q <= row_start_d;
      row_end_q   <= row_end_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      high_q      <= high_d;
    end
  end

`ifndef SYNTHESIS
  // A pixel only leaves on the second byte of a pair
  a_pix_needs_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o |-> (phase_q && !is_command_i && take_i))
    else $error("pixel emitted without a held high byte");

  // A command byte always restarts the byte phase
  a_cmd_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && is_command_i) |=> !phase_q)
    else $error("byte phase not cleared by command");
`endif

endmodule

// ===== hdl/owpw_out_stage.sv =====
// Output register with a skid entry so input can flow while the sink stalls.
module owpw_out_stage import owpw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  pixel_t pix_i,
  output logic   space_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pixel_t out_pix_o
);

  logic   out_valid_q, out_valid_d;
  logic   skid_q, skid_d;
  pixel_t out_q, out_d, skid_pix_q, skid_pix_d;
  logic   stalled;

  assign stalled = out_valid_q && !out_ready_i;
  assign space_o = !skid_q;

  // Steer new results into the output register or the skid entry
  always_comb begin
    out_valid_d = out_valid_q;
    skid_d      = skid_q;
    out_d       = out_q;
    skid_pix_d  = skid_pix_q;
    if (stalled) begin
      if (push_i) begin
        skid_d     = 1'b1;
        skid_pix_d = pix_i;
      end
    end else if (skid_q) begin
      out_valid_d = 1'b1;
      out_d       = skid_pix_q;
      skid_d      = 1'b0;
    end else begin
      out_valid_d = push_i;
      out_d       = pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_q      <= skid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    skid_pix_q <= skid_pix_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_q;

`ifndef SYNTHESIS
  // The skid entry is only filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_q)
    else $error("skid entry full while output empty");

  // A result pushed while stalled lands in the skid entry
  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && stalled) |=> skid_q)
    else $error("stalled push lost");

  // No push may arrive while the skid entry is occupied
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> !push_i)
    else $error("push into full output stage");
`endif

endmodule

// ===== hdl/oled_window_pixel_writer.sv =====
// Output: each pixel is registered in the output stage, or in the skid entry while the sink stalls.
// Throughput: one byte per cycle; the skid entry keeps input flowing for one
// extra pixel while the sink stalls, after which input ready drops.
// Reset: asynchronous, active low; clears window, cursor, command and phase
// state, and loads the command codes with 21, 117 and 92.
module oled_window_pixel_writer import owpw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  owpw_byte_if.sink           in_byte,
  owpw_pixel_if.source        out_pixel,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cmd_codes_t codes;
  logic       space;
  logic       take;
  logic       pix_valid;
  pixel_t     pix, out_pix;

  // Byte transfer on valid and ready
  assign in_byte.ready = space;
  assign take          = in_byte.valid & space;

  owpw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes_o (codes)
  );

  owpw_window_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .is_command_i (in_byte.is_command),
    .bus_byte_i   (in_byte.bus_byte),
    .codes_i      (codes),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix)
  );

  owpw_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pix_valid),
    .pix_i       (pix),
    .space_o     (space),
    .out_valid_o (out_pixel.valid),
    .out_ready_i (out_pixel.ready),
    .out_pix_o   (out_pix)
  );

  assign out_pixel.pixel_x     = out_pix.x;
  assign out_pixel.pixel_y     = out_pix.y;
  assign out_pixel.pixel_color = out_pix.color;

endmodule

// ===== test/oled_window_pixel_writer_tb.sv =====
// Self-checking testbench for the OLED window pixel writer: byte stream in, pixels out.
module oled_window_pixel_writer_tb;
  import owpw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic             is_command;
    logic [ByteW-1:0] bus_byte;
  } byte_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  owpw_byte_if  byte_bus ();
  owpw_pixel_if pix_bus ();

  oled_window_pixel_writer dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte   (byte_bus),
    .out_pixel (pix_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to be sent, and pixels the block still owes us
  byte_item_t  byte_q [$];
  pixel_t      pixel_exp [$];

  // Shadow copy of the command codes and of the window/cursor state
  logic [ByteW-1:0] code_col;
  logic [ByteW-1:0] code_row;
  logic [ByteW-1:0] code_ram;
  logic [ByteW-1:0] cur_cmd;
  logic             byte_phase;
  logic [ByteW-1:0] held_hi;
  int unsigned      col_lo, col_hi, row_lo, row_hi;
  int unsigned      cur_x, cur_y;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_reqs;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned mismatch_cnt;
  int unsigned idle_cycles;

  function automatic void flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit) $display("%s", msg);
  endfunction

  function automatic void push_item(input logic cmd, input logic [ByteW-1:0] b);
    byte_item_t it;
    it.is_command = cmd;
    it.bus_byte   = b;
    byte_q.push_back(it);
  endfunction

  // Coordinate bytes: mostly on-panel, some at the edges, some needing the clamp
  function automatic logic [ByteW-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return ByteW'($urandom_range(255, 128));
      1:       return '0;
      2:       return ByteW'(DisplayWidth - 1);
      default: return ByteW'($urandom_range(127));
    endcase
  endfunction

  // Expected behaviour of one accepted byte; queues the pixel it produces, if any
  function automatic void predict_byte(input byte_item_t it);
    int unsigned v;
    pixel_t      px;
    if (it.is_command) begin
      cur_cmd    = it.bus_byte;
      byte_phase = 1'b0;
    end else if (cur_cmd == code_col) begin
      v = (it.bus_byte >= DisplayWidth) ? DisplayWidth - 1 : it.bus_byte;
      if (!byte_phase) begin
        col_lo     = v;
        cur_x      = v;
        byte_phase = 1'b1;
      end else begin
        col_hi = v;
      end
    end else if (cur_cmd == code_row) begin
      v = (it.bus_byte >= DisplayHeight) ? DisplayHeight - 1 : it.bus_byte;
      if (!byte_phase) begin
        row_lo     = v;
        cur_y      = v;
        byte_phase = 1'b1;
      end else begin
        row_hi = v;
      end
    end else if (cur_cmd == code_ram) begin
      if (!byte_phase) begin
        held_hi    = it.bus_byte;
        byte_phase = 1'b1;
      end else begin
        byte_phase = 1'b0;
        px.x       = CoordW'(cur_x);
        px.y       = CoordW'(cur_y);
        px.color   = {held_hi, it.bus_byte};
        pixel_exp.push_back(px);
        // advance and wrap inside the window; wide counters so 127+1 does not fold
        cur_x++;
        if (cur_x > col_hi) begin
          cur_x = col_lo;
          cur_y++;
          if (cur_y > row_hi) cur_y = row_lo;
        end
      end
    end
  endfunction

  // Byte driver: keeps an offered byte until its transfer, idles at random otherwise
  always @(posedge clk_i) begin : byte_driver
    bit offer;
    if (rst_ni) begin
      if (byte_bus.valid && byte_bus.ready) predict_byte(byte_q.pop_front());
      if (byte_bus.valid && !byte_bus.ready) offer = 1'b1;
      else offer = (byte_q.size() != 0) && ($urandom_range(99) >= src_idle_pct);
      byte_bus.valid <= offer;
      if (offer) begin
        byte_bus.is_command <= byte_q[0].is_command;
        byte_bus.bus_byte   <= byte_q[0].bus_byte;
      end
    end
  end

  // Pixel monitor and sink ready, with the occasional long hold-off
  always @(posedge clk_i) begin : pixel_monitor
    pixel_t exp_px;
    if (rst_ni) begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (pixel_exp.size() == 0) begin
          flag_error($sformatf("unexpected pixel: x=%0d y=%0d colour=%h",
                               pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color));
        end else begin
          exp_px = pixel_exp.pop_front();
          if (exp_px.x !== pix_bus.pixel_x || exp_px.y !== pix_bus.pixel_y ||
              exp_px.color !== pix_bus.pixel_color) begin
            flag_error($sformatf("pixel mismatch: exp x=%0d y=%0d colour=%h, got x=%0d y=%0d colour=%h",
                                 exp_px.x, exp_px.y, exp_px.color,
                                 pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_bus.ready <= 1'b0;
      end else if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HoldCycles - 1;
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: cycles with work outstanding but no transfer on either side
  always @(posedge clk_i) begin : watchdog
    if ((byte_bus.valid && byte_bus.ready) || (pix_bus.valid && pix_bus.ready) ||
        (byte_q.size() == 0 && pixel_exp.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // APB write: setup then access, register taken when the access completes
  task automatic write_code(input reg_idx_e idx, input logic [ByteW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= ApbDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSetColumn: code_col = val;
      RegSetRow:    code_row = val;
      RegWriteRam:  code_ram = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [ByteW-1:0] c, input logic [ByteW-1:0] r,
                           input logic [ByteW-1:0] w);
    write_code(RegSetColumn, c);
    write_code(RegSetRow, r);
    write_code(RegWriteRam, w);
  endtask

  // Block is idle once every byte is in and every pixel out; allow the pipe to settle
  task automatic drain();
    while (byte_q.size() != 0 || pixel_exp.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Random traffic: mostly well-formed command sequences, some noise
  task automatic queue_random(input int unsigned n);
    int unsigned      cnt, k, kind;
    logic [ByteW-1:0] first;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(99);
      if (kind < 36) begin
        // window setting: start, usually an end nearby, sometimes repeated ends
        push_item(1'b1, (kind < 18) ? code_col : code_row);
        first = rand_coord();
        push_item(1'b0, first);
        k = $urandom_range(2);
        repeat (k) begin
          if ($urandom_range(3) == 0) push_item(1'b0, rand_coord());
          else push_item(1'b0, ByteW'(first + $urandom_range(6)));
        end
        cnt += 2 + k;
      end else if (kind < 84) begin
        // pixel burst, now and then cut off after a high byte
        push_item(1'b1, code_ram);
        k = $urandom_range(1, 8);
        repeat (2 * k) push_item(1'b0, ByteW'($urandom_range(255)));
        cnt += 1 + 2 * k;
        if ($urandom_range(7) == 0) begin
          push_item(1'b0, ByteW'($urandom_range(255)));
          cnt++;
        end
      end else if (kind < 92) begin
        // arbitrary command followed by data that may be ignored
        push_item(1'b1, ByteW'($urandom_range(255)));
        k = $urandom_range(1, 3);
        repeat (k) push_item(1'b0, ByteW'($urandom_range(255)));
        cnt += 1 + k;
      end else begin
        push_item(1'(($urandom_range(1))), ByteW'($urandom_range(255)));
        cnt++;
      end
    end
  endtask

  // Main sequence: reset, directed bytes, then random phases over several code sets
  initial begin : stimulus
    int unsigned phase_len;
    rst_ni              = 1'b0;
    byte_bus.valid      = 1'b0;
    byte_bus.is_command = 1'b0;
    byte_bus.bus_byte   = '0;
    pix_bus.ready       = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    src_idle_pct        = 0;
    snk_stall_pct       = 0;
    hold_reqs           = 0;
    hold_served         = 0;
    hold_left           = 0;
    mismatch_cnt        = 0;
    idle_cycles         = 0;
    code_col            = SetColumnReset;
    code_row            = SetRowReset;
    code_ram            = WriteRamReset;
    cur_cmd             = '0;
    byte_phase          = 1'b0;
    held_hi             = '0;
    col_lo = 0; col_hi = 0; row_lo = 0; row_hi = 0;
    cur_x  = 0; cur_y  = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // clamped start and end, then a repeated end that inverts the column window
    push_item(1'b1, SetColumnReset);
    push_item(1'b0, 8'd200);
    push_item(1'b0, 8'd128);
    push_item(1'b0, 8'd1);
    // inverted row window at the bottom edge
    push_item(1'b1, SetRowReset);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h00);
    // two pixels, each wrapping both axes
    push_item(1'b1, WriteRamReset);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'h00);
    // unknown commands: their data must be ignored
    push_item(1'b1, 8'hFF);
    push_item(1'b0, 8'hAA);
    push_item(1'b1, 8'h00);
    push_item(1'b0, 8'h55);
    // narrow column window, then a pixel pair split by a fresh write-RAM command
    push_item(1'b1, SetColumnReset);
    push_item(1'b0, 8'd2);
    push_item(1'b0, 8'd3);
    push_item(1'b1, WriteRamReset);
    push_item(1'b0, 8'hF8);
    push_item(1'b1, WriteRamReset);
    push_item(1'b0, 8'h07);
    push_item(1'b0, 8'hE0);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'h1F);
    drain();

    for (int p = 0; p < 7; p++) begin
      // code sets: extremes, all equal, and pairwise collisions
      case (p)
        1: set_codes(8'd0, 8'd255, 8'd128);
        2: set_codes(8'd255, 8'd0, 8'd1);
        3: set_codes(8'd7, 8'd7, 8'd7);
        4: set_codes(8'd40, 8'd40, 8'd200);
        5: set_codes(8'd3, 8'd250, 8'd250);
        6: set_codes(SetColumnReset, SetRowReset, WriteRamReset);
        default: ;
      endcase
      @(negedge clk_i);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 56; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 56; end
        default: begin src_idle_pct = 38; snk_stall_pct = 38; end
      endcase
      phase_len = (p == 3 || p == 5 || p == 6) ? 150 : 350;
      queue_random(phase_len);
      // long sink hold-off while bytes keep coming, so the input backs up
      if (p == 0 || p == 4) hold_reqs++;
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
